// ===== rtl/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg: shared definitions for the first-fit heap allocator
// Field widths, operation and register codes, reset values and the
// command/status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package ffa_pkg;

   localparam int ADDR_W    = 32;
   localparam int OP_W      = 2;
   localparam int SIZE_W    = 14;
   localparam int HDR_W     = 14;
   localparam int CSR_IDX_W = 2;

   localparam int DEFAULT_HEAP_WORDS  = 1024;
   localparam int DEFAULT_ALIGN_BYTES = 8;

   // operation codes
   localparam logic [OP_W-1:0] OP_MALLOC  = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
   localparam logic [OP_W-1:0] OP_REALLOC = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_SIZE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_REQUEST = 2'd2;

   localparam logic [ADDR_W-1:0] HEAP_BASE_RESET   = 32'd0;
   localparam logic [SIZE_W-1:0] HEAP_SIZE_RESET   = 14'd8192;
   localparam logic [SIZE_W-1:0] MAX_REQUEST_RESET = 14'd8192;

   // divider operand select
   localparam logic [1:0] DIV_SEL_HSIZE = 2'd0;
   localparam logic [1:0] DIV_SEL_REQ   = 2'd1;
   localparam logic [1:0] DIV_SEL_FREE  = 2'd2;

   typedef struct packed {
      logic       latch_req;
      logic       clr_result;
      logic       div_start;
      logic [1:0] div_sel;
      logic       fmt_clear;
      logic       fmt_load;
      logic       need_load;
      logic       walk_start;
      logic       walk_step;
      logic       split_write;
      logic       malloc_done;
      logic       free_ok_load;
      logic       free_start;
      logic       free_write;
      logic       rsp_load;
   } ffa_cmd_type;

   typedef struct packed {
      logic            fmt_pending;
      logic            div_done;
      logic [OP_W-1:0] op;
      logic            pa_null;
      logic            req_zero;
      logic            req_ok;
      logic            heap_empty;
      logic            fit;
      logic            split;
      logic            walk_end;
      logic            free_valid;
      logic            rsp_free;
   } ffa_sts_type;

endpackage

// ===== rtl/ffa_if.sv =====
// ----------------------------------------------------------------------------
// ffa_if: channel interfaces of the first-fit heap allocator
// Request, response and register-write channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface ffa_req_if;
   logic                       valid;
   logic                       ready;
   logic [ffa_pkg::OP_W-1:0]   operation;
   logic [ffa_pkg::ADDR_W-1:0] request_size;
   logic [ffa_pkg::ADDR_W-1:0] payload_address;

   modport source (output valid, operation, request_size, payload_address, input ready);
   modport sink   (input valid, operation, request_size, payload_address, output ready);
endinterface

interface ffa_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       success;
   logic [ffa_pkg::ADDR_W-1:0] result_address;

   modport source (output valid, success, result_address, input ready);
   modport sink   (input valid, success, result_address, output ready);
endinterface

interface ffa_csr_if;
   logic                          valid;
   logic                          ready;
   logic [ffa_pkg::CSR_IDX_W-1:0] index;
   logic [ffa_pkg::ADDR_W-1:0]    wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== rtl/ffa_div.sv =====
// ----------------------------------------------------------------------------
// ffa_div: divider by the power-of-two alignment
// Shifts out the alignment bits and flags a zero remainder; the result is
// registered and ready the cycle after start.
// ----------------------------------------------------------------------------
module ffa_div #(
   parameter int DIVISOR = ffa_pkg::DEFAULT_ALIGN_BYTES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ffa_pkg::ADDR_W-1:0] dividend,
   output logic                       done,
   output logic [ffa_pkg::ADDR_W-1:0] quotient,
   output logic                       rem_zero
);

   localparam int AW    = ffa_pkg::ADDR_W;
   localparam int SHIFT = $clog2(DIVISOR);
   localparam logic [AW-1:0] REM_MASK = AW'(DIVISOR - 1);

   logic [AW-1:0] quot_ff, quot_in;
   logic          rem_zero_ff, rem_zero_in;
   logic          done_ff, done_in;

   always_comb begin
      quot_in     = quot_ff;
      rem_zero_in = rem_zero_ff;
      done_in     = start;
      if (start) begin
         quot_in     = dividend >> SHIFT;
         rem_zero_in = ((dividend & REM_MASK) == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      quot_ff     <= quot_in;
      rem_zero_ff <= rem_zero_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;
   assign rem_zero = rem_zero_ff;

endmodule

// ===== rtl/ffa_dp.sv =====
// ----------------------------------------------------------------------------
// ffa_dp: allocator datapath
// Configuration registers, header memory, walk pointer, request capture,
// shared divider and the response register.
// ----------------------------------------------------------------------------
module ffa_dp #(
   parameter int HEAP_WORDS  = ffa_pkg::DEFAULT_HEAP_WORDS,
   parameter int ALIGN_BYTES = ffa_pkg::DEFAULT_ALIGN_BYTES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ffa_pkg::ffa_cmd_type          cmd,
   output ffa_pkg::ffa_sts_type          sts,
   input  logic                          csr_valid,
   input  logic [ffa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ffa_pkg::ADDR_W-1:0]    csr_wdata,
   input  logic [ffa_pkg::OP_W-1:0]      req_operation,
   input  logic [ffa_pkg::ADDR_W-1:0]    req_request_size,
   input  logic [ffa_pkg::ADDR_W-1:0]    req_payload_address,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_success,
   output logic [ffa_pkg::ADDR_W-1:0]    rsp_result_address
);

   localparam int AW      = ffa_pkg::ADDR_W;
   localparam int HW      = ffa_pkg::HDR_W;
   localparam int SW      = ffa_pkg::SIZE_W;
   localparam int UNITS_W = HW - 1;
   localparam int IDX_W   = $clog2(HEAP_WORDS);
   localparam int W_W     = $clog2(HEAP_WORDS + 1);
   localparam int SUM_W   = ((W_W > UNITS_W) ? W_W : UNITS_W) + 1;
   localparam logic [AW-1:0] ALIGN_A = AW'(ALIGN_BYTES);
   localparam logic [AW-1:0] WORDS_A = AW'(HEAP_WORDS);

   // headers hold payload units in [HW-1:1] and the used flag in [0]
   logic [HW-1:0] mem [HEAP_WORDS];
   logic [HW-1:0] rd_data_ff;

   logic [AW-1:0]                base_ff;
   logic [SW-1:0]                hsize_ff;
   logic [SW-1:0]                maxreq_ff;
   logic                         fmt_pend_ff;
   logic [ffa_pkg::OP_W-1:0]     op_ff;
   logic [AW-1:0]                req_ff;
   logic [AW-1:0]                pa_ff;
   logic [UNITS_W-1:0]           need_ff;
   logic [W_W-1:0]               used_ff;
   logic [W_W-1:0]               w_ff;
   logic [UNITS_W-1:0]           split_rem_ff;
   logic [IDX_W-1:0]             fidx_ff;
   logic                         ok_ff;
   logic [AW-1:0]                addr_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_ok_ff;
   logic [AW-1:0]                rsp_addr_ff;

   logic [AW-1:0]      dividend;
   logic               div_done;
   logic [AW-1:0]      quotient;
   logic               rem_zero;
   logic [AW-1:0]      words_cap;
   logic [UNITS_W-1:0] units;
   logic               used_bit;
   logic               fit;
   logic               split;
   logic [SUM_W-1:0]   w_next;
   logic               walk_end;
   logic [SUM_W-1:0]   nw;
   logic               free_valid;
   logic [AW-1:0]      qm1;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_wa;
   logic [HW-1:0]      mem_wd;
   logic               mem_re;
   logic [IDX_W-1:0]   mem_ra;

   always_comb begin
      unique case (cmd.div_sel)
         ffa_pkg::DIV_SEL_HSIZE: dividend = AW'(hsize_ff);
         ffa_pkg::DIV_SEL_REQ:   dividend = req_ff + AW'(ALIGN_BYTES - 1);
         ffa_pkg::DIV_SEL_FREE:  dividend = pa_ff - base_ff;
         default:                dividend = '0;
      endcase
   end

   ffa_div #(
      .DIVISOR (ALIGN_BYTES)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .done     (div_done),
      .quotient (quotient),
      .rem_zero (rem_zero)
   );

   // heap word count: cap at the memory depth, too small means no block
   always_comb begin
      words_cap = (quotient > WORDS_A) ? WORDS_A : quotient;
      if (words_cap < AW'(2)) begin
         words_cap = '0;
      end
   end

   assign units    = rd_data_ff[HW-1:1];
   assign used_bit = rd_data_ff[0];
   assign fit      = !used_bit && (units >= need_ff);
   assign split    = ({1'b0, units} >= ({1'b0, need_ff} + (UNITS_W + 1)'(2)));
   assign w_next   = SUM_W'(w_ff) + SUM_W'(1) + SUM_W'(units);
   assign walk_end = (w_next >= SUM_W'(used_ff));
   assign nw       = SUM_W'(w_ff) + SUM_W'(1) + SUM_W'(need_ff);

   assign qm1        = quotient - AW'(1);
   assign free_valid = (pa_ff != '0) && rem_zero && (quotient != '0) && (qm1 < AW'(used_ff));

   always_comb begin
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = '0;
      priority if (cmd.fmt_load) begin
         mem_we = (words_cap != '0);
         mem_wd = {UNITS_W'(words_cap - AW'(1)), 1'b0};
      end else if (cmd.walk_step && fit) begin
         mem_we = 1'b1;
         mem_wa = IDX_W'(w_ff);
         mem_wd = split ? {need_ff, 1'b1} : {units, 1'b1};
      end else if (cmd.split_write) begin
         mem_we = 1'b1;
         mem_wa = nw[IDX_W-1:0];
         mem_wd = {split_rem_ff, 1'b0};
      end else if (cmd.free_write) begin
         mem_we = 1'b1;
         mem_wa = fidx_ff;
         mem_wd = {rd_data_ff[HW-1:1], 1'b0};
      end else begin
         mem_we = 1'b0;
      end
   end

   always_comb begin
      mem_re = 1'b0;
      mem_ra = '0;
      priority if (cmd.walk_start) begin
         mem_re = 1'b1;
      end else if (cmd.walk_step && !fit && !walk_end) begin
         mem_re = 1'b1;
         mem_ra = w_next[IDX_W-1:0];
      end else if (cmd.free_start) begin
         mem_re = 1'b1;
         mem_ra = qm1[IDX_W-1:0];
      end else begin
         mem_re = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= ffa_pkg::HEAP_BASE_RESET;
         hsize_ff     <= ffa_pkg::HEAP_SIZE_RESET;
         maxreq_ff    <= ffa_pkg::MAX_REQUEST_RESET;
         fmt_pend_ff  <= 1'b1;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.fmt_clear) begin
            fmt_pend_ff <= 1'b0;
         end
         // a new heap size wins over a format just started
         if (csr_valid) begin
            unique case (csr_index)
               ffa_pkg::CSR_HEAP_BASE: begin
                  base_ff <= csr_wdata;
               end
               ffa_pkg::CSR_HEAP_SIZE: begin
                  hsize_ff    <= csr_wdata[SW-1:0];
                  fmt_pend_ff <= 1'b1;
               end
               ffa_pkg::CSR_MAX_REQUEST: begin
                  maxreq_ff <= csr_wdata[SW-1:0];
               end
               default: begin
               end
            endcase
         end
         if (cmd.fmt_load) begin
            used_ff <= W_W'(words_cap);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff  <= req_operation;
         req_ff <= req_request_size;
         pa_ff  <= req_payload_address;
      end
      if (cmd.need_load) begin
         need_ff <= UNITS_W'(quotient);
      end
      if (cmd.walk_start) begin
         w_ff <= '0;
      end else if (cmd.walk_step && !fit && !walk_end) begin
         w_ff <= W_W'(w_next);
      end
      if (cmd.walk_step && fit) begin
         split_rem_ff <= units - need_ff - UNITS_W'(1);
      end
      if (cmd.free_start) begin
         fidx_ff <= qm1[IDX_W-1:0];
      end
      if (cmd.clr_result) begin
         ok_ff   <= 1'b0;
         addr_ff <= '0;
      end else if (cmd.malloc_done) begin
         ok_ff   <= 1'b1;
         addr_ff <= base_ff + ((AW'(w_ff) + AW'(1)) * ALIGN_A);
      end else if (cmd.free_ok_load) begin
         ok_ff <= free_valid;
      end
      if (cmd.rsp_load) begin
         rsp_ok_ff   <= ok_ff;
         rsp_addr_ff <= addr_ff;
      end
   end

   always_comb begin
      sts.fmt_pending = fmt_pend_ff;
      sts.div_done    = div_done;
      sts.op          = op_ff;
      sts.pa_null     = (pa_ff == '0);
      sts.req_zero    = (req_ff == '0);
      sts.req_ok      = (req_ff != '0) && (req_ff <= AW'(maxreq_ff));
      sts.heap_empty  = (used_ff == '0);
      sts.fit         = fit;
      sts.split       = split;
      sts.walk_end    = walk_end;
      sts.free_valid  = free_valid;
      sts.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_success        = rsp_ok_ff;
   assign rsp_result_address = rsp_addr_ff;

endmodule

// ===== rtl/ffa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffa_ctrl: allocator controller
// Sequences formatting, the first-fit walk, splitting, freeing and the
// response transfer by commands to the datapath.
// ----------------------------------------------------------------------------
module ffa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ffa_pkg::ffa_sts_type sts,
   output ffa_pkg::ffa_cmd_type cmd
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_FMT_DIV  = 4'd1;
   localparam logic [3:0] ST_DISPATCH = 4'd2;
   localparam logic [3:0] ST_M_DIV    = 4'd3;
   localparam logic [3:0] ST_M_START  = 4'd4;
   localparam logic [3:0] ST_M_CHK    = 4'd5;
   localparam logic [3:0] ST_M_SPLIT  = 4'd6;
   localparam logic [3:0] ST_M_DONE   = 4'd7;
   localparam logic [3:0] ST_F_DIV    = 4'd8;
   localparam logic [3:0] ST_F_WR     = 4'd9;
   localparam logic [3:0] ST_RESULT   = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       free_after_ff, free_after_in;
   logic       free_report_ff, free_report_in;
   logic       go_malloc;
   logic       go_free;

   always_comb begin
      cmd            = '0;
      state_in       = state_ff;
      free_after_in  = free_after_ff;
      free_report_in = free_report_ff;
      req_ready      = 1'b0;
      go_malloc      = 1'b0;
      go_free        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (sts.fmt_pending) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = ffa_pkg::DIV_SEL_HSIZE;
               cmd.fmt_clear = 1'b1;
               state_in      = ST_FMT_DIV;
            end else begin
               req_ready = 1'b1;
               if (req_valid) begin
                  cmd.latch_req = 1'b1;
                  state_in      = ST_DISPATCH;
               end
            end
         end
         ST_FMT_DIV: begin
            if (sts.div_done) begin
               cmd.fmt_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DISPATCH: begin
            cmd.clr_result = 1'b1;
            free_after_in  = 1'b0;
            free_report_in = 1'b0;
            unique case (sts.op)
               ffa_pkg::OP_MALLOC: begin
                  go_malloc = 1'b1;
               end
               ffa_pkg::OP_FREE: begin
                  free_report_in = 1'b1;
                  go_free        = 1'b1;
               end
               ffa_pkg::OP_REALLOC: begin
                  priority if (sts.pa_null) begin
                     go_malloc = 1'b1;
                  end else if (sts.req_zero) begin
                     go_free = 1'b1;
                  end else begin
                     free_after_in = 1'b1;
                     go_malloc     = 1'b1;
                  end
               end
               default: begin
                  state_in = ST_RESULT;
               end
            endcase
            if (go_malloc) begin
               if (sts.req_ok) begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = ffa_pkg::DIV_SEL_REQ;
                  state_in      = ST_M_DIV;
               end else begin
                  state_in = ST_RESULT;
               end
            end
            if (go_free) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = ffa_pkg::DIV_SEL_FREE;
               state_in      = ST_F_DIV;
            end
         end
         ST_M_DIV: begin
            if (sts.div_done) begin
               cmd.need_load = 1'b1;
               state_in      = ST_M_START;
            end
         end
         ST_M_START: begin
            if (sts.heap_empty) begin
               state_in = ST_RESULT;
            end else begin
               cmd.walk_start = 1'b1;
               state_in       = ST_M_CHK;
            end
         end
         ST_M_CHK: begin
            // one header a cycle: claim it, advance to the next one, or end the walk
            cmd.walk_step = 1'b1;
            priority if (sts.fit) begin
               state_in = sts.split ? ST_M_SPLIT : ST_M_DONE;
            end else if (sts.walk_end) begin
               state_in = ST_RESULT;
            end else begin
               state_in = ST_M_CHK;
            end
         end
         ST_M_SPLIT: begin
            cmd.split_write = 1'b1;
            state_in        = ST_M_DONE;
         end
         ST_M_DONE: begin
            cmd.malloc_done = 1'b1;
            if (free_after_ff) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = ffa_pkg::DIV_SEL_FREE;
               state_in      = ST_F_DIV;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_F_DIV: begin
            if (sts.div_done) begin
               cmd.free_ok_load = free_report_ff;
               if (sts.free_valid) begin
                  cmd.free_start = 1'b1;
                  state_in       = ST_F_WR;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_F_WR: begin
            cmd.free_write = 1'b1;
            state_in       = ST_RESULT;
         end
         ST_RESULT: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         free_after_ff  <= 1'b0;
         free_report_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         free_after_ff  <= free_after_in;
         free_report_ff <= free_report_in;
      end
   end

endmodule

// ===== rtl/first_fit_implicit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_implicit_heap_allocator: first-fit allocator over implicit headers
// Top level joining the controller and the datapath to the three channels.
// ----------------------------------------------------------------------------
// One request is handled at a time, one response per request. After reset,
// and after every write of the heap size register, the heap is reformatted as
// one free block, during which no request is taken (register writes are always
// taken). ALIGN_BYTES must be a power of two: sizes and addresses are converted
// to heap words by a registered shift and mask. A malloc divides the request
// size, then walks the headers first-fit in turn, since the header memory
// gives one registered read a cycle; a split of the chosen block adds a header
// write before the result. A rejected size answers without a walk. A free
// divides the address offset and clears the used flag unless the address is
// bad; a realloc that both allocates and frees runs the walk, then the free. The
// controller then returns to idle before it takes the next request, and a
// response waits while the previous one is still held in the output register.
// A new request may be taken while the previous response still waits in the
// output register.
module first_fit_implicit_heap_allocator #(
   parameter int HEAP_WORDS  = ffa_pkg::DEFAULT_HEAP_WORDS,
   parameter int ALIGN_BYTES = ffa_pkg::DEFAULT_ALIGN_BYTES
) (
   input  logic      clock,
   input  logic      reset,
   ffa_req_if.sink   req_if,
   ffa_rsp_if.source rsp_if,
   ffa_csr_if.sink   csr_if
);

   ffa_pkg::ffa_cmd_type cmd;
   ffa_pkg::ffa_sts_type sts;

   assign csr_if.ready = 1'b1;

   ffa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffa_dp #(
      .HEAP_WORDS  (HEAP_WORDS),
      .ALIGN_BYTES (ALIGN_BYTES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .csr_valid           (csr_if.valid),
      .csr_index           (csr_if.index),
      .csr_wdata           (csr_if.wdata),
      .req_operation       (req_if.operation),
      .req_request_size    (req_if.request_size),
      .req_payload_address (req_if.payload_address),
      .rsp_valid           (rsp_if.valid),
      .rsp_ready           (rsp_if.ready),
      .rsp_success         (rsp_if.success),
      .rsp_result_address  (rsp_if.result_address)
   );

endmodule

// ===== sim/tb_first_fit_implicit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_first_fit_implicit_heap_allocator: self-checking bench for the allocator
// Drives malloc, free and realloc requests at random pacing and keeps a
// first-fit model of the header store that predicts every response. The
// responses are checked field by field, across several heap layouts.
// ----------------------------------------------------------------------------
module tb_first_fit_implicit_heap_allocator;
   import ffa_pkg::*;

   localparam int WORDS = DEFAULT_HEAP_WORDS;
   localparam int ALIGN = DEFAULT_ALIGN_BYTES;

   typedef struct packed {
      logic              success;
      logic [ADDR_W-1:0] result_address;
   } alloc_rsp_type;

   logic clock;
   logic reset;

   ffa_req_if req_ch ();
   ffa_rsp_if rsp_ch ();
   ffa_csr_if csr_ch ();

   first_fit_implicit_heap_allocator #(
      .HEAP_WORDS  (WORDS),
      .ALIGN_BYTES (ALIGN)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // heap model: registers, header words and the live payload addresses
   logic [ADDR_W-1:0] cfg_base;
   logic [SIZE_W-1:0] cfg_size;
   logic [SIZE_W-1:0] cfg_max_req;
   logic [HDR_W-1:0]  heap_hdr [WORDS];
   int unsigned       heap_words;
   logic [ADDR_W-1:0] live_addr_q [$];
   logic [ADDR_W-1:0] last_grant;

   alloc_rsp_type expected_rsp_q [$];
   int unsigned   fail_count;
   int unsigned   send_gap_pct;
   int unsigned   rsp_stall_pct;

   always #6 clock = ~clock;

   function automatic void format_heap_model();
      int unsigned words;
      words = cfg_size / ALIGN;
      if (words > WORDS) words = WORDS;
      if (words < 2) words = 0;
      heap_words = words;
      foreach (heap_hdr[i]) heap_hdr[i] = '0;
      if (words != 0) heap_hdr[0] = HDR_W'((words - 1) * ALIGN);
      live_addr_q.delete();
   endfunction

   function automatic bit first_fit(input logic [ADDR_W-1:0] req,
                                    output logic [ADDR_W-1:0] addr);
      int unsigned need;
      int unsigned w;
      int unsigned sz;
      int unsigned nw;
      bit          found;
      addr  = '0;
      found = 1'b0;
      if (req == 0 || req > cfg_max_req) return 1'b0;
      need = ((req + ALIGN - 1) / ALIGN) * ALIGN;
      w = 0;
      while (w < heap_words && !found) begin
         sz = {heap_hdr[w][HDR_W-1:1], 1'b0};
         if (!heap_hdr[w][0] && sz >= need) begin
            // split only when the remainder holds a header and one unit
            if (sz >= need + 2 * ALIGN) begin
               nw = w + 1 + need / ALIGN;
               if (nw < WORDS) heap_hdr[nw] = HDR_W'(sz - need - ALIGN);
               heap_hdr[w] = HDR_W'(need | 1);
            end else begin
               heap_hdr[w][0] = 1'b1;
            end
            addr  = cfg_base + ADDR_W'((w + 1) * ALIGN);
            found = 1'b1;
         end else begin
            w += 1 + sz / ALIGN;
         end
      end
      if (found) begin
         live_addr_q.push_back(addr);
         last_grant = addr;
      end
      return found;
   endfunction

   function automatic bit release_block(input logic [ADDR_W-1:0] pa);
      logic [ADDR_W-1:0] off;
      int unsigned       idx;
      int                hits [$];
      if (pa == 0) return 1'b0;
      off = pa - cfg_base;
      if (off % ALIGN != 0) return 1'b0;
      idx = off / ALIGN;
      if (idx < 1 || idx - 1 >= heap_words) return 1'b0;
      heap_hdr[idx-1][0] = 1'b0;
      hits = live_addr_q.find_first_index(x) with (x == pa);
      if (hits.size() != 0) live_addr_q.delete(hits[0]);
      return 1'b1;
   endfunction

   function automatic alloc_rsp_type apply_heap_op(input logic [OP_W-1:0]   op,
                                                   input logic [ADDR_W-1:0] size,
                                                   input logic [ADDR_W-1:0] pa);
      alloc_rsp_type     r;
      logic [ADDR_W-1:0] a;
      r = '0;
      a = '0;
      case (op)
         OP_MALLOC: r.success = first_fit(size, a);
         OP_FREE:   r.success = release_block(pa);
         OP_REALLOC: begin
            if (pa == 0) begin
               r.success = first_fit(size, a);
            end else if (size == 0) begin
               void'(release_block(pa));
            end else begin
               // keep the old block unless the new one was granted
               r.success = first_fit(size, a);
               if (r.success) void'(release_block(pa));
            end
         end
         default: ;
      endcase
      if (r.success && op != OP_FREE) r.result_address = a;
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] pick_size(input int unsigned biggest);
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 85) return $urandom_range(1, biggest);
      if (p < 95) return $urandom_range(1, cfg_max_req + 2 * ALIGN);
      return $urandom();
   endfunction

   task automatic send_op(input logic [OP_W-1:0]   op,
                          input logic [ADDR_W-1:0] size,
                          input logic [ADDR_W-1:0] pa);
      if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.operation       <= op;
      req_ch.request_size    <= size;
      req_ch.payload_address <= pa;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_rsp_q.push_back(apply_heap_op(op, size, pa));
   endtask

   // hold the request side until every outstanding response has arrived
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         CSR_HEAP_BASE:   cfg_base = value;
         CSR_MAX_REQUEST: cfg_max_req = value[SIZE_W-1:0];
         CSR_HEAP_SIZE: begin
            cfg_size = value[SIZE_W-1:0];
            format_heap_model();
         end
         default: ;
      endcase
   endtask

   // the heap size goes last, as its transfer reformats the heap
   task automatic reformat_heap(input logic [ADDR_W-1:0] base,
                                input logic [ADDR_W-1:0] size_bytes,
                                input logic [ADDR_W-1:0] max_req);
      drain();
      write_reg(CSR_HEAP_BASE, base);
      write_reg(CSR_MAX_REQUEST, max_req);
      write_reg(CSR_HEAP_SIZE, size_bytes);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic test_default_heap();
      logic [ADDR_W-1:0] moved;
      send_op(OP_MALLOC, 0, 0);
      send_op(OP_MALLOC, 8193, 0);
      send_op(OP_MALLOC, 32'hFFFF_FFFF, 0);
      send_op(OP_MALLOC, 1, 32'hFFFF_FFFF);
      send_op(OP_REALLOC, 20, 0);
      send_op(OP_FREE, 0, 8);
      send_op(OP_FREE, 0, 8);
      send_op(OP_FREE, 0, 0);
      send_op(OP_FREE, 0, 13);
      send_op(OP_FREE, 0, WORDS * ALIGN + ALIGN);
      send_op(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(OP_MALLOC, 100, 0);
      moved = last_grant;
      send_op(OP_REALLOC, 32'h8000_0000, moved);
      send_op(OP_REALLOC, 200, moved);
      send_op(OP_REALLOC, 0, last_grant);
   endtask

   task automatic test_small_heaps();
      reformat_heap(0, 0, MAX_REQUEST_RESET);
      send_op(OP_MALLOC, 8, 0);
      reformat_heap(0, 15, MAX_REQUEST_RESET);
      send_op(OP_MALLOC, 1, 0);
      reformat_heap(0, 16, MAX_REQUEST_RESET);
      send_op(OP_MALLOC, 8, 0);
      send_op(OP_MALLOC, 1, 0);
      // 24 free bytes: a 16-byte request takes all, an 8-byte one splits
      reformat_heap(0, 32, MAX_REQUEST_RESET);
      send_op(OP_MALLOC, 16, 0);
      reformat_heap(0, 32, MAX_REQUEST_RESET);
      send_op(OP_MALLOC, 8, 0);
      send_op(OP_MALLOC, 8, 0);
   endtask

   task automatic test_wrap_and_limits();
      reformat_heap(32'hFFFF_FFF8, 16383, 1);
      send_op(OP_MALLOC, 1, 0);
      send_op(OP_MALLOC, 2, 0);
      send_op(OP_FREE, 0, 32'hFFFF_FFF8);
      reformat_heap(32'hFFFF_FFF8, 16383, 16383);
      send_op(OP_MALLOC, 1, 0);
      send_op(OP_MALLOC, 8168, 0);
      send_op(OP_MALLOC, 16383, 0);
      send_op(OP_FREE, 0, 16);
   endtask

   task automatic random_item(input int unsigned biggest);
      int unsigned       pick;
      logic [ADDR_W-1:0] target;
      pick   = $urandom_range(0, 99);
      target = (live_addr_q.size() != 0) ?
               live_addr_q[$urandom_range(0, live_addr_q.size() - 1)] : $urandom();
      if (pick < 40) send_op(OP_MALLOC, pick_size(biggest), $urandom());
      else if (pick < 68) send_op(OP_FREE, $urandom(), target);
      else if (pick < 80) send_op(OP_REALLOC, pick_size(biggest), target);
      else if (pick < 83) send_op(OP_REALLOC, 0, target);
      else if (pick < 88) send_op(OP_REALLOC, pick_size(biggest), 0);
      else begin
         case ($urandom_range(0, 5))
            0: send_op(OP_NONE, $urandom(), $urandom());
            1: send_op(OP_FREE, $urandom(), $urandom());
            2: send_op(OP_FREE, $urandom(),
                       cfg_base + ADDR_W'(ALIGN * $urandom_range(0, heap_words + 2)));
            3: send_op(OP_FREE, $urandom(),
                       cfg_base + ADDR_W'(ALIGN * $urandom_range(1, heap_words + 1))
                       + ADDR_W'($urandom_range(1, ALIGN - 1)));
            4: send_op(OP_MALLOC, 0, $urandom());
            default: send_op(OP_REALLOC, $urandom(), $urandom());
         endcase
      end
   endtask

   task automatic run_random_phase(input int unsigned       n_items,
                                   input logic [ADDR_W-1:0] base,
                                   input logic [ADDR_W-1:0] size_bytes,
                                   input logic [ADDR_W-1:0] max_req,
                                   input int unsigned       biggest);
      reformat_heap(base, size_bytes, max_req);
      for (int unsigned k = 0; k < n_items; k++) begin
         if (k == n_items / 2) drain();
         random_item(biggest);
      end
   endtask

   // response side: stall in bursts, then check each transfer in order
   initial begin : rsp_pacing
      int unsigned hold;
      hold = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold == 0 && rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct)
            hold = $urandom_range(1, 7);
         if (hold != 0) begin
            rsp_ch.ready <= 1'b0;
            hold--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      alloc_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsp_q.size() == 0) begin
            $error("response with none outstanding: success %0d result_address %h",
                   rsp_ch.success, rsp_ch.result_address);
            fail_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_ch.success !== want.success) begin
               $error("success: expected %0d, actual %0d", want.success, rsp_ch.success);
               fail_count++;
            end
            if (rsp_ch.result_address !== want.result_address) begin
               $error("result_address: expected %h, actual %h",
                      want.result_address, rsp_ch.result_address);
               fail_count++;
            end
         end
      end
   end

   initial begin
      clock                  = 1'b0;
      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.operation       = OP_MALLOC;
      req_ch.request_size    = '0;
      req_ch.payload_address = '0;
      csr_ch.valid           = 1'b0;
      csr_ch.index           = CSR_HEAP_BASE;
      csr_ch.wdata           = '0;
      fail_count             = 0;
      last_grant             = '0;
      send_gap_pct           = 30;
      rsp_stall_pct          = 30;
      cfg_base               = HEAP_BASE_RESET;
      cfg_size               = HEAP_SIZE_RESET;
      cfg_max_req            = MAX_REQUEST_RESET;
      format_heap_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_default_heap();
      test_small_heaps();
      test_wrap_and_limits();

      send_gap_pct = 20; rsp_stall_pct = 20;
      run_random_phase(150, $urandom(), 256, 8192, 64);
      send_gap_pct = 50; rsp_stall_pct = 0;
      run_random_phase(150, $urandom(), $urandom_range(16, 600), $urandom_range(1, 8192), 48);
      send_gap_pct = 0; rsp_stall_pct = 50;
      run_random_phase(150, $urandom(), 8192, 16383, 600);
      send_gap_pct = 30; rsp_stall_pct = 30;
      run_random_phase(150, $urandom(), $urandom_range(16, 1024), 8192, 96);
      send_gap_pct = 10; rsp_stall_pct = 10;
      run_random_phase(150, $urandom(), 16383, $urandom_range(512, 8192), 1024);
      send_gap_pct = 25; rsp_stall_pct = 25;
      run_random_phase(150, $urandom(), $urandom_range(0, 64), $urandom_range(1, 64), 24);
      // payload addresses wrap past the top of the address space
      send_gap_pct = 40; rsp_stall_pct = 10;
      run_random_phase(150, 32'hFFFF_FE00 + $urandom_range(0, 255), 512, 8192, 64);
      send_gap_pct = 20; rsp_stall_pct = 20;
      run_random_phase(150, $urandom(), $urandom_range(16, 2048), 8192, 128);
      send_gap_pct = 0; rsp_stall_pct = 0;
      run_random_phase(150, $urandom(), 1024, 8192, 64);

      drain();
      repeat (80) @(posedge clock);
      if (fail_count == 0 && expected_rsp_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // worst case: 1400 requests, each a realloc walking ~512 headers with two
   // divider passes, full idle and stall bursts, plus the reformat passes
   initial begin
      #40_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== first_fit_implicit_heap_allocator.f =====
rtl/ffa_pkg.sv
rtl/ffa_if.sv
rtl/ffa_div.sv
rtl/ffa_dp.sv
rtl/ffa_ctrl.sv
rtl/first_fit_implicit_heap_allocator.sv
sim/tb_first_fit_implicit_heap_allocator.sv
